>>> rtl/rti_pkg.sv
// rti_pkg: shared types and register indexes for the ray/triangle intersect block
// no dependencies
package rti_pkg;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t REG_ORIGIN_X = 3'd0;
  localparam cfg_idx_t REG_ORIGIN_Y = 3'd1;
  localparam cfg_idx_t REG_ORIGIN_Z = 3'd2;
  localparam cfg_idx_t REG_DIR_X    = 3'd3;
  localparam cfg_idx_t REG_DIR_Y    = 3'd4;
  localparam cfg_idx_t REG_DIR_Z    = 3'd5;

endpackage

>>> rtl/ray_triangle_intersect.sv
// ray_triangle_intersect: moller-trumbore ray/triangle test, fully pipelined
// depends on rti_pkg
//
// Use: the ray (origin and direction, signed fixed point) is written through
// the cfg_ channel (cfg_ready is always high) while no triangle is in flight.
// Triangles enter on the in_ channel, one transfer per cycle at most; each
// gives exactly one result on the out_ channel, in order: out_hit and the
// intersection point, saturated, zero on a miss.
// The pipeline from input transfer to out_valid has three stages of edges,
// cross and dot products, one stage of sign fix and bound tests, one restoring
// divider stage per quotient bit of t (COORD_BITS + FRAC_BITS + 3 of them),
// one multiply stage and the output register.
// Throughput is one triangle per cycle while no result is stalled. When the
// receiver stalls a valid result, the whole pipeline holds and in_stall is
// raised in the same cycle; nothing is lost or repeated.
// Reset clears the ray registers to zero and empties the pipeline.
module ray_triangle_intersect #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  rti_pkg::cfg_idx_t            cfg_index,
  input  logic        [COORD_BITS-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_vert0_x,
  input  logic signed [COORD_BITS-1:0] in_vert0_y,
  input  logic signed [COORD_BITS-1:0] in_vert0_z,
  input  logic signed [COORD_BITS-1:0] in_vert1_x,
  input  logic signed [COORD_BITS-1:0] in_vert1_y,
  input  logic signed [COORD_BITS-1:0] in_vert1_z,
  input  logic signed [COORD_BITS-1:0] in_vert2_x,
  input  logic signed [COORD_BITS-1:0] in_vert2_y,
  input  logic signed [COORD_BITS-1:0] in_vert2_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic signed [COORD_BITS-1:0] out_hit_x,
  output logic signed [COORD_BITS-1:0] out_hit_y,
  output logic signed [COORD_BITS-1:0] out_hit_z
);
  import rti_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int EW = C + 1;
  localparam int HW = 2 * C + 2;
  localparam int QW = 2 * C + 3;
  localparam int NW = 3 * C + 7;
  localparam int TB = C + FRAC_BITS + 3;
  localparam int RW = NW + FRAC_BITS + TB;
  localparam int PW = C + TB + 1;

  localparam logic [TB-1:0] T_LIM = {{(TB-1){1'b0}}, 1'b1} << (TB - 1);
  localparam logic signed [PW:0] S_MAX = ({{PW{1'b0}}, 1'b1} << (C - 1)) - 1'b1;
  localparam logic signed [PW:0] S_MIN = -({{PW{1'b0}}, 1'b1} << (C - 1));

  typedef struct packed {
    logic          vld;
    logic          hit;
    logic          ovf;
    logic [RW-1:0] rem;
    logic [NW-1:0] den;
    logic [TB-1:0] quo;
  } div_t;

  logic signed [C-1:0] org_r [3];
  logic signed [C-1:0] dir_r [3];

  logic adv;

  // stage 1
  logic                 s1_vld_r;
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [EW-1:0] sv_r [3];
  logic signed [C-1:0]  v0 [3];
  logic signed [C-1:0]  v1 [3];
  logic signed [C-1:0]  v2 [3];

  // stage 2
  logic                 s2_vld_r;
  logic signed [EW-1:0] e1b_r [3];
  logic signed [EW-1:0] e2b_r [3];
  logic signed [EW-1:0] svb_r [3];
  logic signed [HW-1:0] h_r [3];
  logic signed [QW-1:0] q_r [3];
  logic signed [HW-1:0] h_nxt [3];
  logic signed [QW-1:0] q_nxt [3];

  // stage 3
  logic                 s3_vld_r;
  logic signed [NW-1:0] det_r, un_r, vn_r, tn_r;
  logic signed [NW-1:0] det_nxt, un_nxt, vn_nxt, tn_nxt;

  // sign fix, tests, divider
  logic signed [NW-1:0] detp, unp, vnp, tnp;
  logic [RW-1:0]        num;
  div_t                 dv_r [TB+1];
  div_t                 dv_nxt [TB+1];

  // multiply stage
  logic                 sm_vld_r, sm_hit_r;
  logic signed [PW-1:0] prod_r [3];
  logic signed [PW-1:0] prod_nxt [3];
  logic [TB-1:0]        t_val;

  // output
  logic                 out_valid_r, out_hit_r;
  logic signed [C-1:0]  pt_r [3];
  logic signed [C-1:0]  pt_nxt [3];
  logic signed [PW:0]   sum;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // ray registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        org_r[k] <= '0;
        dir_r[k] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X: org_r[0] <= cfg_data;
        REG_ORIGIN_Y: org_r[1] <= cfg_data;
        REG_ORIGIN_Z: org_r[2] <= cfg_data;
        REG_DIR_X:    dir_r[0] <= cfg_data;
        REG_DIR_Y:    dir_r[1] <= cfg_data;
        REG_DIR_Z:    dir_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign v0[0] = in_vert0_x;
  assign v0[1] = in_vert0_y;
  assign v0[2] = in_vert0_z;
  assign v1[0] = in_vert1_x;
  assign v1[1] = in_vert1_y;
  assign v1[2] = in_vert1_z;
  assign v2[0] = in_vert2_x;
  assign v2[1] = in_vert2_y;
  assign v2[2] = in_vert2_z;

  // cross products
  always_comb begin
    h_nxt[0] = HW'(dir_r[1]) * HW'(e2_r[2]) - HW'(dir_r[2]) * HW'(e2_r[1]);
    h_nxt[1] = HW'(dir_r[2]) * HW'(e2_r[0]) - HW'(dir_r[0]) * HW'(e2_r[2]);
    h_nxt[2] = HW'(dir_r[0]) * HW'(e2_r[1]) - HW'(dir_r[1]) * HW'(e2_r[0]);
    q_nxt[0] = QW'(sv_r[1]) * QW'(e1_r[2]) - QW'(sv_r[2]) * QW'(e1_r[1]);
    q_nxt[1] = QW'(sv_r[2]) * QW'(e1_r[0]) - QW'(sv_r[0]) * QW'(e1_r[2]);
    q_nxt[2] = QW'(sv_r[0]) * QW'(e1_r[1]) - QW'(sv_r[1]) * QW'(e1_r[0]);
  end

  // dot products
  always_comb begin
    det_nxt = NW'(e1b_r[0]) * NW'(h_r[0]) + NW'(e1b_r[1]) * NW'(h_r[1])
            + NW'(e1b_r[2]) * NW'(h_r[2]);
    un_nxt  = NW'(svb_r[0]) * NW'(h_r[0]) + NW'(svb_r[1]) * NW'(h_r[1])
            + NW'(svb_r[2]) * NW'(h_r[2]);
    vn_nxt  = NW'(dir_r[0]) * NW'(q_r[0]) + NW'(dir_r[1]) * NW'(q_r[1])
            + NW'(dir_r[2]) * NW'(q_r[2]);
    tn_nxt  = NW'(e2b_r[0]) * NW'(q_r[0]) + NW'(e2b_r[1]) * NW'(q_r[1])
            + NW'(e2b_r[2]) * NW'(q_r[2]);
  end

  // sign fix and bound tests, then the divider stages
  always_comb begin
    logic [RW-1:0] sh;
    if (det_r[NW-1]) begin
      detp = -det_r;
      unp  = -un_r;
      vnp  = -vn_r;
      tnp  = -tn_r;
    end else begin
      detp = det_r;
      unp  = un_r;
      vnp  = vn_r;
      tnp  = tn_r;
    end
    num           = RW'(unsigned'(tnp)) << FRAC_BITS;
    dv_nxt[0].vld = s3_vld_r;
    dv_nxt[0].hit = (det_r != '0) && !unp[NW-1] && !(unp > detp) && !vnp[NW-1]
                  && !((unp + vnp) > detp) && !tnp[NW-1];
    dv_nxt[0].ovf = num >= (RW'(unsigned'(detp)) << TB);
    dv_nxt[0].rem = num;
    dv_nxt[0].den = unsigned'(detp);
    dv_nxt[0].quo = '0;
    // restoring divider, one quotient bit per stage
    for (int j = 0; j < TB; j++) begin
      sh = RW'(dv_r[j].den) << (TB - 1 - j);
      dv_nxt[j+1] = dv_r[j];
      if (dv_r[j].rem >= sh) begin
        dv_nxt[j+1].rem              = dv_r[j].rem - sh;
        dv_nxt[j+1].quo[TB - 1 - j]  = 1'b1;
      end
    end
  end

  // clamp t and scale the direction
  always_comb begin
    if (dv_r[TB].ovf || (dv_r[TB].quo > T_LIM)) begin
      t_val = T_LIM;
    end else begin
      t_val = dv_r[TB].quo;
    end
    for (int k = 0; k < 3; k++) begin
      prod_nxt[k] = PW'(dir_r[k]) * PW'(signed'({1'b0, t_val}));
    end
  end

  // add origin and saturate; a miss gives a zero point
  always_comb begin
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      sum = (PW+1)'(prod_r[k] >>> FRAC_BITS) + (PW+1)'(org_r[k]);
      if (!sm_hit_r) begin
        pt_nxt[k] = '0;
      end else if (sum > S_MAX) begin
        pt_nxt[k] = S_MAX[C-1:0];
      end else if (sum < S_MIN) begin
        pt_nxt[k] = S_MIN[C-1:0];
      end else begin
        pt_nxt[k] = sum[C-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      sm_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j <= TB; j++) begin
        dv_r[j].vld <= 1'b0;
      end
    end else if (adv) begin
      s1_vld_r    <= in_valid;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      for (int j = 0; j <= TB; j++) begin
        dv_r[j] <= dv_nxt[j];
      end
      sm_vld_r    <= dv_r[TB].vld;
      out_valid_r <= sm_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        e1_r[k]   <= EW'(v1[k]) - EW'(v0[k]);
        e2_r[k]   <= EW'(v2[k]) - EW'(v0[k]);
        sv_r[k]   <= EW'(org_r[k]) - EW'(v0[k]);
        e1b_r[k]  <= e1_r[k];
        e2b_r[k]  <= e2_r[k];
        svb_r[k]  <= sv_r[k];
        h_r[k]    <= h_nxt[k];
        q_r[k]    <= q_nxt[k];
        prod_r[k] <= prod_nxt[k];
        pt_r[k]   <= pt_nxt[k];
      end
      det_r     <= det_nxt;
      un_r      <= un_nxt;
      vn_r      <= vn_nxt;
      tn_r      <= tn_nxt;
      sm_hit_r  <= dv_r[TB].hit;
      out_hit_r <= sm_hit_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_hit_x = pt_r[0];
  assign out_hit_y = pt_r[1];
  assign out_hit_z = pt_r[2];

endmodule

>>> rtl/rti_checker.sv
// rti_checker: port-level checks for ray_triangle_intersect, bound into ray_triangle_intersect
// depends on rti_pkg and ray_triangle_intersect
module rti_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_hit,
  input logic [COORD_BITS-1:0] out_hit_x,
  input logic [COORD_BITS-1:0] out_hit_y,
  input logic [COORD_BITS-1:0] out_hit_z
);
  import rti_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) && $stable(out_hit_x)
      && $stable(out_hit_y) && $stable(out_hit_z))
    else $error("stalled result changed");

  // a miss carries a zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_x == '0 && out_hit_y == '0 && out_hit_z == '0)
    else $error("miss with non-zero point");

  // input held back only by a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  // out_valid low after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind ray_triangle_intersect rti_checker #(.COORD_BITS(COORD_BITS)) u_rti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_hit   (out_hit),
  .out_hit_x (out_hit_x),
  .out_hit_y (out_hit_y),
  .out_hit_z (out_hit_z)
);
